@@ src/pts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

  // table sizes
  localparam int MAX_TASKS = 16;
  localparam int NUM_SEMS  = 8;

  // fixed field widths
  localparam int KIND_W  = 3;
  localparam int TIME_W  = 32;
  localparam int SEMF_W  = 3;
  localparam int TASKF_W = 4;
  localparam int CFG_W   = 5;

  // derived index and counter widths
  localparam int TASK_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int SEM_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

  // event codes, the remaining codes behave as a tick
  localparam logic [KIND_W-1:0] KIND_TICK        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELAY       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CYCLE_DELAY = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TAKE        = 3'd3;
  localparam logic [KIND_W-1:0] KIND_GIVE        = 3'd4;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACT,
    ST_SCAN,
    ST_DONE
  } pts_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic act;
    logic scan_clr;
    logic scan_step;
    logic finish;
  } pts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_empty;
    logic scan_last;
    logic out_busy;
  } pts_status_t;

endpackage

`default_nettype wire

@@ src/pts_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pts_in_if;
  import pts_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [TIME_W-1:0]   now_time;
  logic [TIME_W-1:0]   delay_ms;
  logic [SEMF_W-1:0]   sem_index;
  logic [TIME_W-1:0]   start_stamp;

  modport source (output valid, kind, now_time, delay_ms, sem_index, start_stamp,
                  input ready);
  modport sink (input valid, kind, now_time, delay_ms, sem_index, start_stamp,
                output ready);
endinterface

`default_nettype wire

@@ src/pts_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pts_out_if;
  import pts_pkg::*;

  logic               valid;
  logic               ready;
  logic [TASKF_W-1:0] next_task;
  logic               found_ready;
  logic               take_granted;
  logic [TIME_W-1:0]  new_stamp;

  modport source (output valid, next_task, found_ready, take_granted, new_stamp,
                  input ready);
  modport sink (input valid, next_task, found_ready, take_granted, new_stamp,
                output ready);
endinterface

`default_nettype wire

@@ src/pts_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pts_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  pts_pkg::pts_status_t status,
  output pts_pkg::pts_cmd_t    cmd
);
  import pts_pkg::*;

  pts_state_t state;
  pts_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_ACT;
        end
      end
      ST_ACT: begin
        cmd.act      = 1'b1;
        cmd.scan_clr = 1'b1;
        state_next   = status.scan_empty ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/pts_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pts_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [pts_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic [pts_pkg::KIND_W-1:0]  in_kind,
  input  wire logic [pts_pkg::TIME_W-1:0]  in_now_time,
  input  wire logic [pts_pkg::TIME_W-1:0]  in_delay_ms,
  input  wire logic [pts_pkg::SEMF_W-1:0]  in_sem_index,
  input  wire logic [pts_pkg::TIME_W-1:0]  in_start_stamp,
  input  pts_pkg::pts_cmd_t                cmd,
  output pts_pkg::pts_status_t             status,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [pts_pkg::TASKF_W-1:0]      out_next_task,
  output logic                             out_found_ready,
  output logic                             out_take_granted,
  output logic [pts_pkg::TIME_W-1:0]       out_new_stamp
);
  import pts_pkg::*;

  // configuration
  logic [CFG_W-1:0]  tasks_in_use;

  // latched item
  logic [KIND_W-1:0] kind_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] delay_q;
  logic [SEMF_W-1:0] sem_q;
  logic [TIME_W-1:0] stamp_q;

  // task table and semaphores
  logic [MAX_TASKS-1:0] task_asleep;
  logic [MAX_TASKS-1:0] task_blocked;
  logic [TIME_W-1:0]    task_wake_time [MAX_TASKS];
  logic [SEMF_W-1:0]    task_blocking_sem [MAX_TASKS];
  logic [TIME_W-1:0]    sem_count [NUM_SEMS];
  logic [NUM_SEMS-1:0]  sem_nonzero;
  logic [TASK_W-1:0]    current_task;

  // scan state
  logic [CNT_W-1:0]  idx;
  logic              found_q;
  logic [TASK_W-1:0] sel_q;
  logic              granted_q;

  logic [CNT_W-1:0]  scan_len;
  logic [TASK_W-1:0] cur;
  logic [TASK_W-1:0] ti;
  logic [SEM_W-1:0]  si;
  logic              sem_ok;
  logic [SEMF_W-1:0] bsem;
  logic              bsem_ok;
  logic              wake_now;
  logic              entry_ready;

  // scan length clamped to the table size
  assign scan_len = (tasks_in_use > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : tasks_in_use;
  assign cur      = current_task;
  assign ti       = idx[TASK_W-1:0];
  assign si       = sem_q[SEM_W-1:0];
  assign sem_ok   = 32'(sem_q) < NUM_SEMS;

  // wake test for the entry under the scan pointer
  assign bsem        = task_blocking_sem[ti];
  assign bsem_ok     = 32'(bsem) < NUM_SEMS;
  assign wake_now    = task_asleep[ti] &&
                       (task_blocked[ti] ? (bsem_ok && sem_nonzero[bsem[SEM_W-1:0]])
                                         : (task_wake_time[ti] <= now_q));
  assign entry_ready = !task_asleep[ti] || wake_now;

  assign status.scan_empty = (scan_len == '0);
  assign status.scan_last  = ((idx + CNT_W'(1)) == scan_len);
  assign status.out_busy   = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tasks_in_use <= CFG_W'(1);
      task_asleep  <= '0;
      task_blocked <= '0;
      sem_nonzero  <= '0;
      current_task <= '0;
      out_valid    <= 1'b0;
      idx          <= '0;
      found_q      <= 1'b0;
      sel_q        <= '0;
      granted_q    <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        task_wake_time[i]    <= '0;
        task_blocking_sem[i] <= '0;
      end
      for (int s = 0; s < NUM_SEMS; s++) begin
        sem_count[s] <= '0;
      end
    end else begin
      // register write
      if (cfg_we) begin
        tasks_in_use <= cfg_wdata;
      end

      // capture the item
      if (cmd.load) begin
        kind_q  <= in_kind;
        now_q   <= in_now_time;
        delay_q <= in_delay_ms;
        sem_q   <= in_sem_index;
        stamp_q <= in_start_stamp + in_delay_ms;
      end

      // event acts on the current task or a semaphore
      if (cmd.act) begin
        granted_q <= 1'b0;
        unique case (kind_q)
          KIND_DELAY: begin
            task_wake_time[cur] <= now_q + delay_q;
            task_asleep[cur]    <= 1'b1;
          end
          KIND_CYCLE_DELAY: begin
            task_wake_time[cur] <= stamp_q;
            if (stamp_q > now_q) begin
              task_asleep[cur] <= 1'b1;
            end
          end
          KIND_TAKE: begin
            if (sem_ok) begin
              if (sem_nonzero[si]) begin
                sem_count[si]   <= sem_count[si] - TIME_W'(1);
                sem_nonzero[si] <= (sem_count[si] != TIME_W'(1));
                granted_q       <= 1'b1;
              end else begin
                task_blocked[cur]      <= 1'b1;
                task_blocking_sem[cur] <= sem_q;
                task_asleep[cur]       <= 1'b1;
              end
            end
          end
          KIND_GIVE: begin
            if (sem_ok && (sem_count[si] != '1)) begin
              sem_count[si]   <= sem_count[si] + TIME_W'(1);
              sem_nonzero[si] <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      // wake and select, one entry per cycle
      if (cmd.scan_clr) begin
        idx     <= '0;
        found_q <= 1'b0;
        sel_q   <= '0;
      end
      if (cmd.scan_step) begin
        if (wake_now) begin
          task_asleep[ti]  <= 1'b0;
          task_blocked[ti] <= 1'b0;
        end
        if (!found_q && entry_ready) begin
          found_q <= 1'b1;
          sel_q   <= ti;
        end
        idx <= idx + CNT_W'(1);
      end

      // result register
      if (cmd.finish) begin
        if (found_q) begin
          current_task <= sel_q;
        end
        out_next_task    <= TASKF_W'(found_q ? sel_q : current_task);
        out_found_ready  <= found_q;
        out_take_granted <= granted_q;
        out_new_stamp    <= stamp_q;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/priority_task_scheduler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Fixed-priority task scheduler. Each item on evt is one event (tick, delay,
// cycle delay, semaphore take or give) with the current time; each event gives
// exactly one item on res: the task to run next, whether a ready task was
// found, whether a take was granted and the next period stamp.
// The tasks_in_use register is written through cfg_we / cfg_wdata; write it
// only while idle, as the block itself does not enforce this. It sets how
// many task entries the wake and select pass visits. An accepted event
// passes the event action, then the N scanned entries (N = tasks_in_use
// clamped to 16) in the shared wake/select stage, then the result register.
// The next event is accepted only after that, so the scan over the task
// table limits the event rate.
// A finished result waits in the output register; evt.ready returns high as
// soon as the result has been loaded. If res is stalled when the next result
// is finished, the block holds that result until the register frees.
// Synchronous reset clears the task table, the semaphore counts and the
// current task, sets tasks_in_use to one and drops res.valid.
module priority_task_scheduler (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [pts_pkg::CFG_W-1:0] cfg_wdata,
  pts_in_if.sink                         evt,
  pts_out_if.source                      res
);
  import pts_pkg::*;

  pts_cmd_t    cmd;
  pts_status_t status;

  // sequencing
  pts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (evt.valid),
    .in_ready (evt.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // task table, semaphores and result register
  pts_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_kind          (evt.kind),
    .in_now_time      (evt.now_time),
    .in_delay_ms      (evt.delay_ms),
    .in_sem_index     (evt.sem_index),
    .in_start_stamp   (evt.start_stamp),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (res.valid),
    .out_ready        (res.ready),
    .out_next_task    (res.next_task),
    .out_found_ready  (res.found_ready),
    .out_take_granted (res.take_granted),
    .out_new_stamp    (res.new_stamp)
  );

endmodule

`default_nettype wire

@@ src/pts_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pts_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        evt_valid,
  input wire logic                        evt_ready,
  input wire logic                        res_valid,
  input wire logic                        res_ready,
  input wire logic [pts_pkg::TASKF_W-1:0] res_next_task,
  input wire logic [pts_pkg::TIME_W-1:0]  res_new_stamp
);
  import pts_pkg::*;

  // one event at a time: no acceptance directly after an acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && evt_ready) |=> !evt_ready)
    else $error("event accepted while previous event still in work");

  // a result never appears in the cycle right after an acceptance
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !$past(evt_valid && evt_ready))
    else $error("result appeared too soon after acceptance");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(res_next_task) && $stable(res_new_stamp)))
    else $error("stalled result changed or dropped");

  // reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (evt_ready && !res_valid))
    else $error("block not idle after reset");

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
  .clk           (clk),
  .rst           (rst),
  .evt_valid     (evt.valid),
  .evt_ready     (evt.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_next_task (res.next_task),
  .res_new_stamp (res.new_stamp)
);

`default_nettype wire

@@ tb/pts_schedule_checker.sv @@
`timescale 1ns / 1ps

module pts_schedule_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [pts_pkg::CFG_W-1:0] cfg_wdata,
  pts_in_if                         evt,
  pts_out_if                        res,
  output int                        outstanding,
  output int                        mismatches
);
  import pts_pkg::*;

  typedef struct packed {
    logic [TASKF_W-1:0] next_task;
    logic               found_ready;
    logic               take_granted;
    logic [TIME_W-1:0]  new_stamp;
  } sched_res_t;

  // shadow copy of the task table, semaphores and scan length
  logic               asleep   [MAX_TASKS];
  logic [TIME_W-1:0]  wake_at  [MAX_TASKS];
  logic               blocked  [MAX_TASKS];
  logic [SEMF_W-1:0]  block_sem[MAX_TASKS];
  logic [TIME_W-1:0]  sem_level[NUM_SEMS];
  logic [TASKF_W-1:0] running;
  logic [CFG_W-1:0]   scan_cfg;

  sched_res_t due_q[$];
  int         bad = 0;

  function automatic void clear_table();
    for (int i = 0; i < MAX_TASKS; i++) begin
      asleep[i]    = 1'b0;
      wake_at[i]   = '0;
      blocked[i]   = 1'b0;
      block_sem[i] = '0;
    end
    for (int s = 0; s < NUM_SEMS; s++) begin
      sem_level[s] = '0;
    end
    running  = '0;
    scan_cfg = 5'd1;
  endfunction

  // apply one event to the shadow state and work out the task to run next
  function automatic sched_res_t schedule_event(
    input logic [KIND_W-1:0] kind,
    input logic [TIME_W-1:0] now,
    input logic [TIME_W-1:0] delay,
    input logic [SEMF_W-1:0] sem,
    input logic [TIME_W-1:0] start
  );
    sched_res_t r;
    int         n;
    logic       sem_ok;
    r.new_stamp    = start + delay;
    r.take_granted = 1'b0;
    r.found_ready  = 1'b0;
    sem_ok         = (int'(sem) < NUM_SEMS);

    // event action on the running task or a semaphore
    case (kind)
      KIND_DELAY: begin
        wake_at[running] = now + delay;
        asleep[running]  = 1'b1;
      end
      KIND_CYCLE_DELAY: begin
        wake_at[running] = r.new_stamp;
        if (r.new_stamp > now) asleep[running] = 1'b1;
      end
      KIND_TAKE: begin
        if (sem_ok) begin
          if (sem_level[sem] != '0) begin
            sem_level[sem] = sem_level[sem] - 1'b1;
            r.take_granted = 1'b1;
          end else begin
            blocked[running]   = 1'b1;
            block_sem[running] = sem;
            asleep[running]    = 1'b1;
          end
        end
      end
      KIND_GIVE: begin
        if (sem_ok && sem_level[sem] != '1) sem_level[sem] = sem_level[sem] + 1'b1;
      end
      default: begin
      end
    endcase

    // wake pass, blocked tasks on their semaphore, the rest on time
    n = (int'(scan_cfg) > MAX_TASKS) ? MAX_TASKS : int'(scan_cfg);
    for (int i = 0; i < n; i++) begin
      if (asleep[i]) begin
        if (blocked[i]) begin
          if (int'(block_sem[i]) < NUM_SEMS && sem_level[block_sem[i]] != '0) begin
            blocked[i] = 1'b0;
            asleep[i]  = 1'b0;
          end
        end else if (wake_at[i] <= now) begin
          asleep[i] = 1'b0;
        end
      end
    end

    // select pass, lowest index wins, else the running task stays
    for (int i = 0; i < n; i++) begin
      if (!r.found_ready && !asleep[i]) begin
        running       = TASKF_W'(i);
        r.found_ready = 1'b1;
      end
    end
    r.next_task = running;
    return r;
  endfunction

  always @(posedge clk) begin
    sched_res_t want;
    sched_res_t got;
    if (rst) begin
      clear_table();
      due_q.delete();
    end else begin
      if (cfg_we) scan_cfg = cfg_wdata;

      // compare the result item with the oldest expectation
      if (res.valid && res.ready) begin
        got = {res.next_task, res.found_ready, res.take_granted, res.new_stamp};
        if (due_q.size() == 0) begin
          bad++;
          $display("%0t: unexpected result, task %0d found %0b granted %0b stamp %08h",
                   $time, got.next_task, got.found_ready, got.take_granted, got.new_stamp);
        end else begin
          want = due_q.pop_front();
          if (got !== want) begin
            bad++;
            $display("%0t: result mismatch, expected task %0d found %0b granted %0b stamp %08h",
                     $time, want.next_task, want.found_ready, want.take_granted,
                     want.new_stamp);
            $display("%0t:                  actual   task %0d found %0b granted %0b stamp %08h",
                     $time, got.next_task, got.found_ready, got.take_granted, got.new_stamp);
          end
        end
      end

      // predict the result of an accepted event item
      if (evt.valid && evt.ready) begin
        due_q.push_back(schedule_event(evt.kind, evt.now_time, evt.delay_ms, evt.sem_index,
                                       evt.start_stamp));
      end
    end
    outstanding <= due_q.size();
    mismatches  <= bad;
  end

endmodule

@@ tb/tb_priority_task_scheduler.sv @@
`timescale 1ns / 1ps

module tb_priority_task_scheduler;
  import pts_pkg::*;

  localparam int ITEMS_PER_PHASE = 120;
  localparam logic [CFG_W-1:0] PHASE_CFG [10] = '{
    5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd8, 5'd16, 5'd5, 5'd12
  };

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               outstanding;
  int               mismatches;
  logic [TIME_W-1:0] clock_ms;
  bit               src_idle_on;

  pts_in_if  evt_if ();
  pts_out_if res_if ();

  priority_task_scheduler u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .evt       (evt_if),
    .res       (res_if)
  );

  pts_schedule_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .evt         (evt_if),
    .res         (res_if),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length, mostly short with the odd long one
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(3, 1);
    if (pick < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // present one event item and hold it until accepted
  task automatic send_event(
    input logic [KIND_W-1:0] kind,
    input logic [TIME_W-1:0] now,
    input logic [TIME_W-1:0] delay,
    input logic [SEMF_W-1:0] sem,
    input logic [TIME_W-1:0] start
  );
    int unsigned gap;
    gap = src_idle_on ? idle_len() : 0;
    if (gap != 0) begin
      evt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt_if.valid       <= 1'b1;
    evt_if.kind        <= kind;
    evt_if.now_time    <= now;
    evt_if.delay_ms    <= delay;
    evt_if.sem_index   <= sem;
    evt_if.start_stamp <= start;
    do @(posedge clk); while (!evt_if.ready);
  endtask

  // wait until every result is back and the block has settled
  task automatic drain();
    evt_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tasks_in_use(input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random event around a slowly advancing system time, with some wild values
  task automatic random_event();
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] start;
    logic [SEMF_W-1:0] sem;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 25) kind = KIND_TICK;
    else if (pick < 45) kind = KIND_DELAY;
    else if (pick < 58) kind = KIND_CYCLE_DELAY;
    else if (pick < 78) kind = KIND_TAKE;
    else if (pick < 95) kind = KIND_GIVE;
    else kind = KIND_W'($urandom_range(7, 5));
    clock_ms = clock_ms + $urandom_range(3);
    now   = ($urandom_range(9) == 0) ? $urandom() : clock_ms;
    delay = ($urandom_range(5) == 0) ? $urandom() : TIME_W'($urandom_range(30));
    start = ($urandom_range(4) == 0) ? $urandom() : clock_ms - $urandom_range(12);
    sem   = SEMF_W'(($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(3));
    send_event(kind, now, delay, sem, start);
  endtask

  // result side back-pressure
  initial begin
    int unsigned run;
    int unsigned hold;
    res_if.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      run  = ($urandom_range(7) == 0) ? $urandom_range(200, 20) : $urandom_range(4, 1);
      hold = idle_len();
      res_if.ready <= 1'b1;
      repeat (run) @(posedge clk);
      if (hold != 0) begin
        res_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    evt_if.valid       <= 1'b0;
    evt_if.kind        <= KIND_TICK;
    evt_if.now_time    <= '0;
    evt_if.delay_ms    <= '0;
    evt_if.sem_index   <= '0;
    evt_if.start_stamp <= '0;
    src_idle_on = 1'b1;
    clock_ms    = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // single task after reset: run, sleep with nothing ready, wake on time
    send_event(KIND_TICK, 32'd0, 32'd0, 3'd0, 32'd0);
    send_event(KIND_DELAY, 32'd5, 32'd10, 3'd0, 32'd0);
    send_event(KIND_TICK, 32'd15, 32'd0, 3'd0, 32'd0);
    drain();

    // four tasks: semaphores, blocking, the delay kinds and wrap-around
    write_tasks_in_use(5'd4);
    send_event(KIND_GIVE, 32'd20, 32'd0, 3'd0, 32'd0);
    send_event(KIND_TAKE, 32'd20, 32'd0, 3'd0, 32'd0);
    send_event(KIND_TAKE, 32'd20, 32'd0, 3'd0, 32'd0);
    send_event(KIND_DELAY, 32'd100, 32'd50, 3'd0, 32'd0);
    send_event(KIND_CYCLE_DELAY, 32'd100, 32'd10, 3'd0, 32'd200);
    send_event(KIND_CYCLE_DELAY, 32'd100, 32'd0, 3'd0, 32'd50);
    send_event(KIND_DELAY, 32'd100, 32'hFFFF_FFFF, 3'd0, 32'd0);
    send_event(KIND_DELAY, 32'd100, 32'd1000, 3'd0, 32'd0);
    send_event(KIND_TICK, 32'd150, 32'd0, 3'd0, 32'd0);
    send_event(KIND_GIVE, 32'd150, 32'd0, 3'd0, 32'd0);
    send_event(KIND_GIVE, 32'd150, 32'd0, 3'd7, 32'd0);
    send_event(KIND_TAKE, 32'd150, 32'd0, 3'd7, 32'd0);
    send_event(KIND_W'(5), 32'hFFFF_FFFF, 32'd0, 3'd0, 32'd0);
    send_event(KIND_W'(6), 32'hFFFF_FFFF, 32'd0, 3'd0, 32'd0);
    send_event(KIND_W'(7), 32'hFFFF_FFFF, 32'd0, 3'd0, 32'd0);
    send_event(KIND_CYCLE_DELAY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0, 32'hFFFF_FFFF);
    send_event(KIND_DELAY, 32'hFFFF_FFFF, 32'd1, 3'd0, 32'd0);
    send_event(KIND_TICK, 32'd0, 32'd0, 3'd0, 32'd0);
    drain();

    // random phases over a spread of scan lengths
    foreach (PHASE_CFG[p]) begin
      write_tasks_in_use(PHASE_CFG[p]);
      case ($urandom_range(2))
        0: clock_ms = '0;
        1: clock_ms = 32'hFFFF_FF00;
        default: clock_ms = $urandom();
      endcase
      src_idle_on = ($urandom_range(2) != 0);
      repeat (ITEMS_PER_PHASE) random_event();
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
